@@ rtl/cei_pkg.sv @@
`default_nettype none

package cei_pkg;

    localparam int COORD_W   = 32;
    localparam int CORNER_W  = 4 * COORD_W;
    localparam int NUM_CORN  = 8;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int QUO_W     = COORD_W + 2;
    localparam int SUM_W     = QUO_W + 2;

    localparam logic [2:0] LAST_CORNER = 3'd7;
    localparam logic [3:0] LAST_EDGE   = 4'd11;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0] c1;
        logic [2:0] c2;
        logic [1:0] axis;
        logic [2:0] base;
    } edge_info_t;

    function automatic edge_info_t edge_lookup(input logic [3:0] e);
        edge_info_t r;
        unique case (e)
            4'd0:    r = '{c1: 3'd0, c2: 3'd1, axis: AXIS_X, base: 3'd0};
            4'd1:    r = '{c1: 3'd1, c2: 3'd2, axis: AXIS_Y, base: 3'd1};
            4'd2:    r = '{c1: 3'd3, c2: 3'd2, axis: AXIS_X, base: 3'd2};
            4'd3:    r = '{c1: 3'd0, c2: 3'd3, axis: AXIS_Y, base: 3'd3};
            4'd4:    r = '{c1: 3'd4, c2: 3'd5, axis: AXIS_X, base: 3'd4};
            4'd5:    r = '{c1: 3'd5, c2: 3'd6, axis: AXIS_Y, base: 3'd5};
            4'd6:    r = '{c1: 3'd7, c2: 3'd6, axis: AXIS_X, base: 3'd6};
            4'd7:    r = '{c1: 3'd4, c2: 3'd7, axis: AXIS_Y, base: 3'd7};
            4'd8:    r = '{c1: 3'd0, c2: 3'd4, axis: AXIS_Z, base: 3'd0};
            4'd9:    r = '{c1: 3'd1, c2: 3'd5, axis: AXIS_Z, base: 3'd1};
            4'd10:   r = '{c1: 3'd3, c2: 3'd7, axis: AXIS_Z, base: 3'd3};
            4'd11:   r = '{c1: 3'd2, c2: 3'd6, axis: AXIS_Z, base: 3'd2};
            default: r = '{c1: 3'd0, c2: 3'd0, axis: AXIS_X, base: 3'd0};
        endcase
        return r;
    endfunction

    // corner word layout: {dist, z, y, x}
    function automatic logic [COORD_W-1:0] coord_sel(input logic [CORNER_W-1:0] w,
                                                     input logic [1:0] axis);
        logic [COORD_W-1:0] r;
        case (axis)
            AXIS_Y:  r = w[2*COORD_W-1:COORD_W];
            AXIS_Z:  r = w[3*COORD_W-1:2*COORD_W];
            default: r = w[COORD_W-1:0];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cei_ram.sv @@
`default_nettype none

module cei_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/cube_edge_interpolation.sv @@
// cube edge interpolation
// input channel (in_valid/in_ready): one corner per transfer, corner number,
//   position pos_x/pos_y/pos_z and distance dist_req, all signed Q16.16
// corners 0..6 are stored and give no result
// corner 7 is stored and then starts one result for each of edges 0..11 in the fixed edge
//   order, each on the output channel (out_valid/out_ready) with the
//   interpolated point, the cube sign index, div_zero and last on edge 11
// one edge: three corner-store reads, difference, one 32x33 multiply, an
//   overflow check and a 34-step restoring divider (one quotient bit per
//   cycle), then saturation; the divider is skipped when the distances are
//   equal or the quotient is out of range
// in_ready is low while edges are being computed
// a result waits in the output register while the next edge is computed;
//   a stalled receiver holds the sequencer only when a new result is ready
// reset clears the sign bits and the sequencer; the corner store is not
//   cleared and must be written before it is read
`default_nettype none

module cube_edge_interpolation
    import cei_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         corner,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] dist_req,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              edge_res,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [7:0]              cube_index,
    output logic                    div_zero,
    output logic                    last
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD1  = 4'd1;
    localparam logic [3:0] S_RD2  = 4'd2;
    localparam logic [3:0] S_RD3  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_PROD = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam int CNT_W = $clog2(QUO_W);

    logic [3:0]       state_reg, state_next;
    logic [3:0]       edge_reg, edge_next;
    logic [7:0]       sign_bits_reg, sign_bits_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIFF_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] dq_reg, dq_next;

    logic [COORD_W-1:0] x1_reg, d1_reg, x2_reg, d2_reg;
    logic [COORD_W-1:0] bx_reg, by_reg, bz_reg;
    logic signed [DIFF_W-1:0] dx_reg, den_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DIFF_W-1:0]  den_mag_reg;
    logic               neg_reg, dz_reg, ovf_reg;

    logic [3:0]         edge_res_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [7:0]         cube_index_reg;
    logic               div_zero_reg, last_reg;

    edge_info_t         einfo;
    logic               in_xfer, out_free;
    logic [2:0]         raddr;
    logic [CORNER_W-1:0] rdata, wdata;

    logic signed [DIFF_W-1:0] dx_c, den_c;
    logic [DIFF_W-1:0]  dx_mag, den_mag_c;
    logic [COORD_W-1:0] d2_mag;
    logic [PROD_W-1:0]  prod_full;
    logic               ovf_c;
    logic [QUO_W:0]     rem2;
    logic [QUO_W:0]     rem2_diff;
    logic               qbit;
    logic signed [SUM_W-1:0] x2_ext, q_ext, sum;
    logic [COORD_W-1:0] sum_sat, axis_val;

    assign einfo    = edge_lookup(edge_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign wdata    = {dist_req, pos_z, pos_y, pos_x};

    always_comb
    begin
        case (state_reg)
            S_RD2:   raddr = einfo.c2;
            S_RD3:   raddr = einfo.base;
            default: raddr = einfo.c1;
        endcase
    end

    cei_ram #(
        .WIDTH (CORNER_W),
        .DEPTH (NUM_CORN)
    ) u_store (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (corner),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // difference, magnitude and product datapath
    assign dx_c      = $signed({x1_reg[COORD_W-1], x1_reg}) - $signed({x2_reg[COORD_W-1], x2_reg});
    assign den_c     = $signed({d1_reg[COORD_W-1], d1_reg}) - $signed({d2_reg[COORD_W-1], d2_reg});
    assign dx_mag    = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign den_mag_c = den_reg[DIFF_W-1] ? DIFF_W'(-den_reg) : DIFF_W'(den_reg);
    assign d2_mag    = d2_reg[COORD_W-1] ? COORD_W'(-d2_reg) : d2_reg;
    assign prod_full = {{(PROD_W-COORD_W){1'b0}}, d2_mag}
                     * {{(PROD_W-DIFF_W){1'b0}}, dx_mag};

    assign ovf_c = {{(DIFF_W-(PROD_W-QUO_W)){1'b0}}, prod_reg[PROD_W-1:QUO_W]} >= den_mag_reg;

    // shared compare and subtract, one quotient bit per cycle
    assign rem2      = {1'b0, rem_reg, dq_reg[QUO_W-1]};
    assign rem2_diff = rem2 - {{(QUO_W+1-DIFF_W){1'b0}}, den_mag_reg};
    assign qbit      = (rem2 >= {{(QUO_W+1-DIFF_W){1'b0}}, den_mag_reg});

    // final add and saturation
    assign x2_ext = {{(SUM_W-COORD_W){x2_reg[COORD_W-1]}}, x2_reg};
    assign q_ext  = {{(SUM_W-QUO_W){1'b0}}, dq_reg};
    assign sum    = neg_reg ? (x2_ext + q_ext) : (x2_ext - q_ext);

    always_comb
    begin
        if (sum[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){sum[SUM_W-1]}})
        begin
            sum_sat = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            sum_sat = sum[COORD_W-1:0];
        end
        if (dz_reg)
        begin
            axis_val = x2_reg;
        end
        else if (ovf_reg)
        begin
            axis_val = neg_reg ? SAT_MAX : SAT_MIN;
        end
        else
        begin
            axis_val = sum_sat;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        edge_next      = edge_reg;
        sign_bits_next = sign_bits_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sign_bits_next[corner] = !dist_req[31] && (dist_req != '0);
                    if (corner == LAST_CORNER)
                    begin
                        state_next = S_RD1;
                        edge_next  = '0;
                    end
                end
            end
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_RD3;
            S_RD3:  state_next = S_MUL;
            S_MUL:  state_next = S_PROD;
            S_PROD: state_next = S_CHK;
            S_CHK:
            begin
                rem_next = {{(DIFF_W-(PROD_W-QUO_W)){1'b0}}, prod_reg[PROD_W-1:QUO_W]};
                dq_next  = prod_reg[QUO_W-1:0];
                cnt_next = '0;
                state_next = (dz_reg || ovf_c) ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                rem_next = qbit ? rem2_diff[DIFF_W-1:0] : rem2[DIFF_W-1:0];
                dq_next  = {dq_reg[QUO_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (edge_reg == LAST_EDGE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        edge_next  = edge_reg + 1'b1;
                        state_next = S_RD1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            edge_reg      <= '0;
            sign_bits_reg <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            edge_reg      <= edge_next;
            sign_bits_reg <= sign_bits_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        case (state_reg)
            S_RD2:
            begin
                x1_reg <= coord_sel(rdata, einfo.axis);
                d1_reg <= rdata[CORNER_W-1:3*COORD_W];
            end
            S_RD3:
            begin
                x2_reg <= coord_sel(rdata, einfo.axis);
                d2_reg <= rdata[CORNER_W-1:3*COORD_W];
            end
            S_MUL:
            begin
                bx_reg  <= rdata[COORD_W-1:0];
                by_reg  <= rdata[2*COORD_W-1:COORD_W];
                bz_reg  <= rdata[3*COORD_W-1:2*COORD_W];
                dx_reg  <= dx_c;
                den_reg <= den_c;
                dz_reg  <= (den_c == '0);
                neg_reg <= d2_reg[COORD_W-1] ^ dx_c[DIFF_W-1] ^ den_c[DIFF_W-1];
            end
            S_PROD:
            begin
                prod_reg    <= prod_full;
                den_mag_reg <= den_mag_c;
            end
            S_CHK:
            begin
                ovf_reg <= ovf_c;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    edge_res_reg   <= edge_reg;
                    out_x_reg      <= (einfo.axis == AXIS_X) ? axis_val : bx_reg;
                    out_y_reg      <= (einfo.axis == AXIS_Y) ? axis_val : by_reg;
                    out_z_reg      <= (einfo.axis == AXIS_Z) ? axis_val : bz_reg;
                    cube_index_reg <= sign_bits_reg;
                    div_zero_reg   <= dz_reg;
                    last_reg       <= (edge_reg == LAST_EDGE);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign edge_res   = edge_res_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;
    assign cube_index = cube_index_reg;
    assign div_zero   = div_zero_reg;
    assign last       = last_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < den_mag_reg)
        else $error("divider remainder not below divisor");

    a_no_div_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !dz_reg)
        else $error("divider started on equal distances");

    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> edge_reg <= LAST_EDGE)
        else $error("edge counter out of range");

    a_short_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && corner != LAST_CORNER |=> state_reg == S_IDLE)
        else $error("corner load left the idle state");

    a_last_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> edge_res == LAST_EDGE)
        else $error("last flag on a result that is not the final edge");

endmodule

`default_nettype wire
